// ===== sv/apr_pkg.sv =====
// Package for the AABB pushback resolver: sizes, the queued transaction type
// and the per-axis result type. Used by every module of the block; no dependencies.
package apr_pkg;
   localparam int Entries = 64;
   localparam int IdxW = 6;
   localparam int CntW = 7;
   localparam int PosW = 32;
   localparam int SizeW = 31;
   localparam int SumW = 40;

   localparam logic ModeWrite = 1'b0;
   localparam logic ModeQuery = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [IdxW-1:0]        idx;
      logic signed [PosW-1:0] px;
      logic signed [PosW-1:0] py;
      logic signed [PosW-1:0] pz;
      logic [SizeW-1:0]       sx;
      logic [SizeW-1:0]       sy;
      logic [SizeW-1:0]       sz;
      logic                   col;
   } item_type;

   typedef struct packed {
      logic                   hit;
      logic [PosW+1:0]        pen;
      logic                   neg;
   } axis_type;
endpackage

// ===== sv/apr_front.sv =====
// Front part of the AABB pushback resolver: a two-entry queue holding accepted
// transactions until the back part takes them. Depends on apr_pkg.
module apr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  apr_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output apr_pkg::item_type out_item
);
   apr_pkg::item_type q_ff [2];
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= in_item;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ===== sv/apr_axis.sv =====
// Overlap test and penetration depth along one axis, combinational.
// Depends on apr_pkg.
module apr_axis (
   input  logic signed [apr_pkg::PosW-1:0] mc,
   input  logic [apr_pkg::SizeW-2:0]       mh,
   input  logic signed [apr_pkg::PosW-1:0] oc,
   input  logic [apr_pkg::SizeW-1:0]       oh,
   output apr_pkg::axis_type               res
);
   logic signed [apr_pkg::PosW+2:0] mlo, mhi, olo, ohi, a, b;
   always_comb begin
      mlo = 35'(mc) - 35'($signed({1'b0, mh}));
      mhi = 35'(mc) + 35'($signed({1'b0, mh}));
      olo = 35'(oc) - 35'($signed({1'b0, oh}));
      ohi = 35'(oc) + 35'($signed({1'b0, oh}));
      a = mhi - olo;
      b = ohi - mlo;
      res.hit = !(mhi < olo || ohi < mlo);
      res.pen = (a < b) ? a[apr_pkg::PosW+1:0] : b[apr_pkg::PosW+1:0];
      res.neg = mc < oc;
   end
endmodule

// ===== sv/apr_back.sv =====
// Back part of the AABB pushback resolver: obstacle memory, the entry sweep
// with registered reads, summing and the output register. Depends on apr_pkg, apr_axis.
module apr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  apr_pkg::item_type         in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [3*apr_pkg::PosW+apr_pkg::CntW:0] out_data
);
   typedef enum logic [3:0] {
      IDLE = 4'b0001, SCAN = 4'b0010, DONE = 4'b0100, SEND = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3*apr_pkg::PosW+3*apr_pkg::SizeW-1:0] mem [apr_pkg::Entries];
   logic [apr_pkg::Entries-1:0] valid_ff;
   logic [apr_pkg::IdxW:0] addr_ff;
   logic rd_vld_ff, rd_ok_ff;
   logic [3*apr_pkg::PosW+3*apr_pkg::SizeW-1:0] rd_ff;
   apr_pkg::item_type q_ff;
   logic signed [apr_pkg::SumW-1:0] sx_ff, sy_ff, sz_ff;
   logic [apr_pkg::CntW-1:0] hits_ff;
   logic [3*apr_pkg::PosW+apr_pkg::CntW:0] out_ff;
   logic signed [apr_pkg::PosW-1:0] ocx, ocy, ocz;
   logic [apr_pkg::SizeW-1:0] ohx, ohy, ohz;
   apr_pkg::axis_type ax, ay, az;
   logic hit;
   logic signed [apr_pkg::SumW-1:0] dx, dy, dz;

   assign {ocx, ocy, ocz, ohx, ohy, ohz} = rd_ff;
   assign in_ready  = state_ff == IDLE;
   assign out_valid = state_ff == SEND;
   assign out_data  = out_ff;

   apr_axis u_ax (.mc(q_ff.px), .mh(q_ff.sx[apr_pkg::SizeW-1:1]), .oc(ocx), .oh(ohx), .res(ax));
   apr_axis u_ay (.mc(q_ff.py), .mh(q_ff.sy[apr_pkg::SizeW-1:1]), .oc(ocy), .oh(ohy), .res(ay));
   apr_axis u_az (.mc(q_ff.pz), .mh(q_ff.sz[apr_pkg::SizeW-1:1]), .oc(ocz), .oh(ohz), .res(az));

   function automatic logic signed [apr_pkg::PosW-1:0] sat(
         input logic signed [apr_pkg::SumW-1:0] v);
      if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -40'sh0080000000) return 32'sh80000000;
      return v[apr_pkg::PosW-1:0];
   endfunction

   always_comb begin
      hit = rd_vld_ff && rd_ok_ff && ax.hit && ay.hit && az.hit;
      dx = '0;
      dy = '0;
      dz = '0;
      if (ax.pen <= ay.pen && ax.pen <= az.pen) begin
         dx = ax.neg ? -40'($signed({1'b0, ax.pen})) : 40'($signed({1'b0, ax.pen}));
      end else if (ay.pen <= az.pen) begin
         dy = ay.neg ? -40'($signed({1'b0, ay.pen})) : 40'($signed({1'b0, ay.pen}));
      end else begin
         dz = az.neg ? -40'($signed({1'b0, az.pen})) : 40'($signed({1'b0, az.pen}));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (in_valid && in_item.mode == apr_pkg::ModeQuery)
            state_in = in_item.col ? SCAN : DONE;
         SCAN: if (addr_ff[apr_pkg::IdxW] && !rd_vld_ff) state_in = DONE;
         DONE: state_in = SEND;
         SEND: if (out_ready) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == IDLE && in_valid && in_item.mode == apr_pkg::ModeWrite) begin
         mem[in_item.idx] <= {in_item.px, in_item.py, in_item.pz,
                              in_item.sx, in_item.sy, in_item.sz};
      end
      rd_ff <= mem[addr_ff[apr_pkg::IdxW-1:0]];
      rd_ok_ff <= valid_ff[addr_ff[apr_pkg::IdxW-1:0]];
      if (state_ff == IDLE && in_valid) begin
         q_ff <= in_item;
      end
      if (state_ff == DONE) begin
         out_ff <= {1'b0, hits_ff, sat(sz_ff), sat(sy_ff), sat(sx_ff)};
      end
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
         addr_ff <= '0;
         rd_vld_ff <= 1'b0;
         sx_ff <= '0;
         sy_ff <= '0;
         sz_ff <= '0;
         hits_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == IDLE && in_valid && in_item.mode == apr_pkg::ModeWrite) begin
            valid_ff[in_item.idx] <= in_item.col;
         end
         if (state_ff == IDLE) begin
            addr_ff <= '0;
            rd_vld_ff <= 1'b0;
            sx_ff <= '0;
            sy_ff <= '0;
            sz_ff <= '0;
            hits_ff <= '0;
         end else if (state_ff == SCAN) begin
            rd_vld_ff <= !addr_ff[apr_pkg::IdxW];
            if (!addr_ff[apr_pkg::IdxW]) addr_ff <= addr_ff + 1'b1;
            if (hit) begin
               sx_ff <= sx_ff + dx;
               sy_ff <= sy_ff + dy;
               sz_ff <= sz_ff + dz;
               hits_ff <= hits_ff + 1'b1;
            end
         end
      end
   end
endmodule

// ===== sv/aabb_pushback_resolver.sv =====
// Top level of the AABB pushback resolver: front queue and back sweep.
// Depends on apr_pkg, apr_front, apr_back.
// A write (mode 0) gives no response; a query is served by the sweep that reads
// the 64-entry obstacle memory one entry a cycle, and returns one response
// transaction. A query from a mover that is not collidable skips the sweep and
// goes from IDLE through DONE to SEND, where its response is valid. The front
// queue holds two transactions so the request side keeps moving while the back
// part is busy, until the queue is full.
module aabb_pushback_resolver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode, entry_index, pos_x, pos_y, pos_z, size_x, size_y, size_z, collides
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // push_x, push_y, push_z, hit_count
   output logic [103:0] rsp_tdata
);
   apr_pkg::item_type in_item, q_item;
   logic q_valid, q_ready;

   assign in_item.mode = req_tdata[0];
   assign in_item.idx  = req_tdata[6:1];
   assign in_item.px   = req_tdata[38:7];
   assign in_item.py   = req_tdata[70:39];
   assign in_item.pz   = req_tdata[102:71];
   assign in_item.sx   = req_tdata[133:103];
   assign in_item.sy   = req_tdata[164:134];
   assign in_item.sz   = req_tdata[195:165];
   assign in_item.col  = req_tdata[196];

   apr_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   apr_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule

// ===== sv/apr_checker.sv =====
// Port-level checks for the AABB pushback resolver, bound to its top level.
// Depends on aabb_pushback_resolver.
module apr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp held");
   a_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[102:96] <= 7'd64) else $error("hit count range");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103] == 1'b0) else $error("pad bits");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("valid after reset");
   a_ready_reset: assert property (@(posedge clock)
      reset |=> req_tready || !req_tvalid || req_tready) else $error("ready after reset");
endmodule

bind aabb_pushback_resolver apr_checker u_apr_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
